// File: sv/plim_pkg.sv
package plim_pkg;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int MAX_POINTS_DEF   = 30;

  localparam int LVL_W = 8;
  localparam int NUM_W = 2 * LVL_W;
  localparam int PTS_W = 5;

  localparam logic [LVL_W-1:0] LVL_MAX   = 8'd255;
  localparam logic [PTS_W-1:0] PTS_RESET = 5'd2;

  localparam logic       ACT_WRITE = 1'b0;
  localparam logic       ACT_MAP   = 1'b1;
  localparam logic [0:0] REG_POINTS_IN_USE = 1'b0;

  typedef struct packed {
    logic [LVL_W-1:0] x;
    logic [LVL_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [LVL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: sv/plim_point_mem.sv
module plim_point_mem #(
  parameter int NUM_CHANNELS = plim_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_POINTS   = plim_pkg::MAX_POINTS_DEF,
  localparam int DEPTH  = NUM_CHANNELS * MAX_POINTS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [ADDR_W-1:0]    waddr_i,
  input  plim_pkg::point_t     wdata_i,
  input  logic [ADDR_W-1:0]    raddr_i,
  output plim_pkg::point_t     rdata_o
);

  plim_pkg::point_t mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  plim_pkg::point_t rd_q;
  logic             rd_valid_q;
  logic             rd_head_q;

  function automatic logic is_head(input logic [ADDR_W-1:0] a);
    logic r;
    r = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (a == ADDR_W'(c * MAX_POINTS)) r = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_head_q  <= 1'b0;
    end else begin
      if (we_i) valid_q[waddr_i] <= 1'b1;
      rd_valid_q <= valid_q[raddr_i];
      rd_head_q  <= is_head(raddr_i);
    end
  end

  always_comb begin
    if (rd_valid_q) begin
      rdata_o = rd_q;
    end else if (rd_head_q) begin
      rdata_o = '0;
    end else begin
      rdata_o.x = plim_pkg::LVL_MAX;
      rdata_o.y = plim_pkg::LVL_MAX;
    end
  end

endmodule

// File: sv/plim_divider.sv
module plim_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plim_pkg::div_req_t req_i,
  output plim_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(plim_pkg::LVL_W);

  logic                       busy_q, busy_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [plim_pkg::LVL_W-1:0] rem_q, rem_d;
  logic [plim_pkg::LVL_W-1:0] quo_q, quo_d;
  logic [plim_pkg::LVL_W-1:0] dvs_q, dvs_d;
  logic                       done_q, done_d;
  logic [plim_pkg::LVL_W:0]   trial;
  logic                       fits;

  // quotient is known to fit in 8 bits, so the upper half seeds the remainder
  assign trial = {rem_q, quo_q[plim_pkg::LVL_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[plim_pkg::NUM_W-1:plim_pkg::LVL_W];
      quo_d  = req_i.dividend[plim_pkg::LVL_W-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? plim_pkg::LVL_W'(trial - {1'b0, dvs_q})
                   : trial[plim_pkg::LVL_W-1:0];
      quo_d = {quo_q[plim_pkg::LVL_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(plim_pkg::LVL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: sv/piecewise_linear_intensity_map_unit.sv
// Piecewise linear intensity map. An item is taken when start is high and busy is low.
// A point write is stored in the cycle it is taken and busy stays low. A map item keeps
// busy high through its states: the point memory is scanned one point per cycle over
// the points_in_use points, the interpolation numerator is formed in S_MUL, the division
// by the segment width runs one quotient bit per cycle and then raises done with the
// quotient, and the result state S_OUT ends it. Uncovered levels and flat segments
// skip the division; unknown channels skip the scan too. The result appears on
// mapped_value_o/covered_o with valid_o for exactly one cycle; it cannot be held off.
module piecewise_linear_intensity_map_unit #(
  parameter int NUM_CHANNELS = plim_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_POINTS   = plim_pkg::MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [1:0]  channel_i,
  input  logic [4:0]  point_index_i,
  input  logic [7:0]  point_x_i,
  input  logic [7:0]  point_y_i,
  input  logic [7:0]  level_i,
  output logic        valid_o,
  output logic [7:0]  mapped_value_o,
  output logic        covered_o
);

  localparam int DEPTH  = NUM_CHANNELS * MAX_POINTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int N_W    = (CNT_W > plim_pkg::PTS_W) ? CNT_W : plim_pkg::PTS_W;
  localparam int LW     = plim_pkg::LVL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [plim_pkg::PTS_W-1:0] pts_q, pts_d;
  logic [N_W-1:0]      n_q, cnt_q, didx_q;
  logic                dvld_q;
  logic [ADDR_W-1:0]   base_q;
  logic [LW-1:0]       k_q;
  plim_pkg::point_t    prev_q;
  logic                sel_cov_q;
  logic [LW-1:0]       sx0_q, sy0_q, sx1_q, sy1_q;
  logic [LW-1:0]       res_val_q;
  logic                res_cov_q;

  logic                cfg_we;
  logic [plim_pkg::PTS_W-1:0] cfg_v;
  logic                accept, ch_ok, mem_we, rd_issue, eval, last;
  logic [ADDR_W-1:0]   waddr, raddr;
  plim_pkg::point_t    wdata, cur;
  logic                a_en, a_cov, b_en, b_cov;
  logic [LW-1:0]       ax0, ay0;
  logic [LW-1:0]       dx;
  logic [plim_pkg::NUM_W-1:0] num;
  plim_pkg::div_req_t  div_req;
  plim_pkg::div_rsp_t  div_rsp;

  function automatic logic seg_covers(input logic [LW-1:0] x0, input logic [LW-1:0] x1,
                                      input logic [LW-1:0] k);
    return ((x1 == x0) && (k == x0)) || ((x1 > x0) && (k >= x0) && (k <= x1));
  endfunction

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == plim_pkg::REG_POINTS_IN_USE);
  assign prdata = (paddr[2] == plim_pkg::REG_POINTS_IN_USE) ? 32'(pts_q) : '0;

  always_comb begin
    cfg_v = pwdata[plim_pkg::PTS_W-1:0];
    if (cfg_v == '0) begin
      cfg_v = plim_pkg::PTS_RESET;
    end else if (N_W'(cfg_v) > N_W'(MAX_POINTS)) begin
      cfg_v = plim_pkg::PTS_W'(MAX_POINTS);
    end
    pts_d = cfg_we ? cfg_v : pts_q;
  end

  // item transfer
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign ch_ok  = 32'(channel_i) < NUM_CHANNELS;
  assign mem_we = accept && (action_i == plim_pkg::ACT_WRITE) && ch_ok &&
                  (32'(point_index_i) < MAX_POINTS);
  assign waddr  = ADDR_W'(32'(channel_i) * MAX_POINTS + 32'(point_index_i));
  assign wdata.x = point_x_i;
  assign wdata.y = point_y_i;

  assign rd_issue = (state_q == S_SCAN) && (cnt_q < n_q);
  assign raddr    = base_q + ADDR_W'(cnt_q[IDX_W-1:0]);

  plim_point_mem #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .MAX_POINTS  (MAX_POINTS)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(cur)
  );

  // segment check on returned point
  assign eval = (state_q == S_SCAN) && dvld_q;
  assign last = (didx_q == n_q - 1'b1);
  assign ax0  = (didx_q == '0) ? '0 : prev_q.x;
  assign ay0  = (didx_q == '0) ? '0 : prev_q.y;
  assign a_en  = (didx_q != '0) || (cur.x != '0);
  assign a_cov = a_en && seg_covers(ax0, cur.x, k_q);
  assign b_en  = last && (cur.x != plim_pkg::LVL_MAX);
  assign b_cov = b_en && seg_covers(cur.x, plim_pkg::LVL_MAX, k_q);

  // interpolation numerator
  assign dx  = sx1_q - sx0_q;
  assign num = plim_pkg::NUM_W'(sy0_q) * plim_pkg::NUM_W'(sx1_q - k_q) +
               plim_pkg::NUM_W'(sy1_q) * plim_pkg::NUM_W'(k_q - sx0_q);

  assign div_req.start    = (state_q == S_MUL) && sel_cov_q && (dx != '0);
  assign div_req.dividend = num;
  assign div_req.divisor  = dx;

  plim_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (action_i == plim_pkg::ACT_MAP)) state_d = ch_ok ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (eval && last) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = div_req.start ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (div_rsp.done) state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pts_q   <= plim_pkg::PTS_RESET;
      cnt_q   <= '0;
      dvld_q  <= 1'b0;
      sel_cov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pts_q   <= pts_d;
      dvld_q  <= rd_issue;
      if (accept) begin
        cnt_q     <= '0;
        sel_cov_q <= 1'b0;
      end else begin
        if (rd_issue) cnt_q <= cnt_q + 1'b1;
        if (eval && (a_cov || b_cov)) sel_cov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q <= cnt_q;
    if (accept) begin
      n_q    <= N_W'(pts_q);
      base_q <= ADDR_W'(32'(channel_i) * MAX_POINTS);
      k_q    <= level_i;
    end
    if (eval) begin
      prev_q <= cur;
      if (b_cov) begin
        sx0_q <= cur.x;
        sy0_q <= cur.y;
        sx1_q <= plim_pkg::LVL_MAX;
        sy1_q <= plim_pkg::LVL_MAX;
      end else if (a_cov) begin
        sx0_q <= ax0;
        sy0_q <= ay0;
        sx1_q <= cur.x;
        sy1_q <= cur.y;
      end
    end
    if (state_q == S_IDLE) begin
      res_val_q <= '0;
      res_cov_q <= 1'b0;
    end else if (state_q == S_MUL) begin
      res_cov_q <= sel_cov_q;
      res_val_q <= (sel_cov_q && (dx == '0)) ? sy0_q : '0;
    end else if ((state_q == S_DIV) && div_rsp.done) begin
      res_val_q <= div_rsp.quot;
    end
  end

  assign valid_o        = (state_q == S_OUT);
  assign mapped_value_o = res_val_q;
  assign covered_o      = res_cov_q;

  a_out_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy)
    else $error("result strobe not followed by idle");

  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !covered_o |-> mapped_value_o == '0)
    else $error("uncovered level gave nonzero value");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside division state");

  a_map_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == plim_pkg::ACT_MAP) |=> busy)
    else $error("map transfer did not raise busy");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q <= n_q)
    else $error("scan read index beyond points in use");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int NCH         = plim_pkg::NUM_CHANNELS_DEF;
  localparam int NPT         = plim_pkg::MAX_POINTS_DEF;
  localparam int SETTLE      = 48;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 500;
  localparam int PHASES      = 6;

  typedef struct packed {
    logic [7:0] value;
    logic       cov;
  } mapped_t;

  typedef struct packed {
    logic       act;
    logic [1:0] ch;
    logic [4:0] idx;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] lvl;
    logic       typed;
    mapped_t    res;
  } item_t;

  // typed rows carry their result; the rest are checked against map_level
  localparam item_t DIRECTED [25] = '{
    '{plim_pkg::ACT_MAP,   2'd0, 5'h15, 8'h5A, 8'hC3, 8'd0,   1'b1, '{8'd0,   1'b1}},
    '{plim_pkg::ACT_MAP,   2'd0, 5'h0A, 8'hA5, 8'h3C, 8'd255, 1'b1, '{8'd255, 1'b1}},
    '{plim_pkg::ACT_MAP,   2'd1, 5'h1F, 8'hFF, 8'hFF, 8'd128, 1'b1, '{8'd128, 1'b1}},
    '{plim_pkg::ACT_MAP,   2'd3, 5'h00, 8'h00, 8'h00, 8'd77,  1'b1, '{8'd0,   1'b0}},
    '{plim_pkg::ACT_WRITE, 2'd3, 5'd0,  8'd10, 8'd200, 8'hA5, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd3, 5'h15, 8'h5A, 8'hC3, 8'd10,  1'b1, '{8'd0,   1'b0}},
    '{plim_pkg::ACT_WRITE, 2'd2, 5'd31, 8'd5,  8'd250, 8'h5A, 1'b0, '0},
    '{plim_pkg::ACT_WRITE, 2'd2, 5'd30, 8'd5,  8'd250, 8'hFF, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd2, 5'h0A, 8'hA5, 8'h3C, 8'd5,   1'b1, '{8'd5,   1'b1}},
    '{plim_pkg::ACT_WRITE, 2'd0, 5'd0,  8'd100, 8'd50, 8'h00, 1'b0, '0},
    '{plim_pkg::ACT_WRITE, 2'd0, 5'd1,  8'd100, 8'd200, 8'hA5, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd0, 5'h15, 8'h5A, 8'hC3, 8'd100, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd0, 5'h0A, 8'hA5, 8'h3C, 8'd99,  1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd0, 5'h1F, 8'hFF, 8'hFF, 8'd101, 1'b0, '0},
    '{plim_pkg::ACT_WRITE, 2'd1, 5'd0,  8'd255, 8'd0,  8'h5A, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd1, 5'h15, 8'h5A, 8'hC3, 8'd255, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd1, 5'h0A, 8'hA5, 8'h3C, 8'd254, 1'b0, '0},
    '{plim_pkg::ACT_WRITE, 2'd2, 5'd0,  8'd0,  8'd255, 8'hFF, 1'b0, '0},
    '{plim_pkg::ACT_WRITE, 2'd2, 5'd1,  8'd255, 8'd0,  8'h00, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd2, 5'h15, 8'h5A, 8'hC3, 8'd0,   1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd2, 5'h0A, 8'hA5, 8'h3C, 8'd1,   1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd2, 5'h1F, 8'hFF, 8'hFF, 8'd255, 1'b0, '0},
    '{plim_pkg::ACT_WRITE, 2'd0, 5'd1,  8'd50, 8'd0,   8'hA5, 1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd0, 5'h15, 8'h5A, 8'hC3, 8'd75,  1'b0, '0},
    '{plim_pkg::ACT_MAP,   2'd0, 5'h0A, 8'hA5, 8'h3C, 8'd0,   1'b0, '0}
  };

  localparam logic [4:0] CFG_STEPS [PHASES-1] = '{5'd1, 5'd30, 5'd31, 5'd0, 5'd3};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start         = 1'b0;
  logic        busy;
  logic        action_i      = plim_pkg::ACT_WRITE;
  logic [1:0]  channel_i     = '0;
  logic [4:0]  point_index_i = '0;
  logic [7:0]  point_x_i     = '0;
  logic [7:0]  point_y_i     = '0;
  logic [7:0]  level_i       = '0;
  logic        valid_o;
  logic [7:0]  mapped_value_o;
  logic        covered_o;

  plim_pkg::point_t curve_pts [NCH][NPT];
  int      curve_len;
  mapped_t pending_maps [$];
  int      errors = 0;
  int      cycles = 0;
  int      sent   = 0;
  bit      idle_ok = 1'b0;

  always #4 clk_i = ~clk_i;

  piecewise_linear_intensity_map_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .channel_i     (channel_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .level_i       (level_i),
    .valid_o       (valid_o),
    .mapped_value_o(mapped_value_o),
    .covered_o     (covered_o)
  );

  function automatic void seg_apply(input int x0, input int y0, input int x1, input int y1,
                                    input int k, inout int val, inout bit cov);
    if (x1 == x0) begin
      if (k == x0) begin
        val = y0;
        cov = 1'b1;
      end
    end else if (x1 > x0 && k >= x0 && k <= x1) begin
      val = (y0 * (x1 - k) + y1 * (k - x0)) / (x1 - x0);
      if (val > 255) val = 255;
      cov = 1'b1;
    end
  endfunction

  // last covering segment wins: head, inner segments, tail
  function automatic mapped_t map_level(input logic [1:0] ch, input logic [7:0] k);
    int      val = 0;
    bit      cov = 1'b0;
    mapped_t r;
    if (ch < NCH) begin
      if (curve_pts[ch][0].x != 0)
        seg_apply(0, 0, curve_pts[ch][0].x, curve_pts[ch][0].y, k, val, cov);
      for (int i = 1; i < curve_len; i++)
        seg_apply(curve_pts[ch][i-1].x, curve_pts[ch][i-1].y,
                  curve_pts[ch][i].x, curve_pts[ch][i].y, k, val, cov);
      if (curve_pts[ch][curve_len-1].x != plim_pkg::LVL_MAX)
        seg_apply(curve_pts[ch][curve_len-1].x, curve_pts[ch][curve_len-1].y,
                  255, 255, k, val, cov);
    end
    r.value = cov ? 8'(val) : 8'd0;
    r.cov   = cov;
    return r;
  endfunction

  function automatic item_t rand_item(input logic act);
    item_t r;
    int    sel;
    r.act   = act;
    r.ch    = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(NCH-1));
    r.idx   = ($urandom_range(99) < 10) ? 5'($urandom) : 5'($urandom_range(curve_len-1));
    r.x     = 8'($urandom);
    r.y     = 8'($urandom);
    sel     = $urandom_range(99);
    if (sel < 5)
      r.lvl = 8'd0;
    else if (sel < 10)
      r.lvl = plim_pkg::LVL_MAX;
    else if (sel < 35)
      r.lvl = curve_pts[$urandom_range(NCH-1)][$urandom_range(curve_len-1)].x;
    else
      r.lvl = 8'($urandom);
    r.typed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  task automatic issue(input item_t r);
    if (idle_ok && $urandom_range(99) < 8) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    action_i      = r.act;
    channel_i     = r.ch;
    point_index_i = r.idx;
    point_x_i     = r.x;
    point_y_i     = r.y;
    level_i       = r.lvl;
    start         = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (r.act == plim_pkg::ACT_WRITE) begin
      if (r.ch < NCH && r.idx < NPT) curve_pts[r.ch][r.idx] = {r.x, r.y};
    end else begin
      pending_maps.push_back(r.typed ? r.res : map_level(r.ch, r.lvl));
    end
    sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // mostly well-formed curves: sorted x, some repeated x
  task automatic load_curve(input logic [1:0] ch, input bit ordered);
    int    xs [$];
    item_t r;
    for (int i = 0; i < curve_len; i++) xs.push_back($urandom_range(255));
    if (ordered) begin
      xs.sort();
      for (int i = 1; i < curve_len; i++)
        if ($urandom_range(99) < 15) xs[i] = xs[i-1];
    end
    for (int i = 0; i < curve_len; i++) begin
      r     = rand_item(plim_pkg::ACT_WRITE);
      r.ch  = ch;
      r.idx = 5'(i);
      r.x   = 8'(xs[i]);
      issue(r);
    end
  endtask

  task automatic drain(input bit settle);
    while (pending_maps.size() != 0) @(negedge clk_i);
    if (settle) repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {plim_pkg::REG_POINTS_IN_USE, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_points(input logic [4:0] v);
    logic [31:0] wd;
    logic [31:0] rd;
    int          n;
    n = v;
    if (n < 1) n = 2;
    if (n > NPT) n = NPT;
    wd      = $urandom;
    wd[4:0] = v;
    apb_xfer(1'b1, wd, rd);
    curve_len = n;
    apb_xfer(1'b0, $urandom, rd);
    if (rd !== 32'(n)) begin
      $display("%0t: points_in_use readback expected %0d actual %0d", $time, n, rd);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    mapped_t want;
    if (rst_ni && valid_o) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected transfer mapped_value=%0d covered=%0b",
                 $time, mapped_value_o, covered_o);
        errors++;
      end else begin
        want = pending_maps.pop_front();
        if (mapped_value_o !== want.value) begin
          $display("%0t: mapped_value expected %0d actual %0d",
                   $time, want.value, mapped_value_o);
          errors++;
        end
        if (covered_o !== want.cov) begin
          $display("%0t: covered expected %0b actual %0b", $time, want.cov, covered_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int target;
    int pick;
    for (int c = 0; c < NCH; c++)
      for (int i = 0; i < NPT; i++)
        curve_pts[c][i] = (i == 0) ? {8'd0, 8'd0} : {plim_pkg::LVL_MAX, plim_pkg::LVL_MAX};
    curve_len = plim_pkg::PTS_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    idle_ok = 1'b1;
    foreach (DIRECTED[i]) issue(DIRECTED[i]);
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(1'b1);
      set_points(ph < PHASES - 1 ? CFG_STEPS[ph] : 5'($urandom_range(2, NPT - 1)));
      idle_ok = (ph != 2);
      target  = sent + RAND_ITEMS / PHASES;
      while (sent < target) begin
        pick = $urandom_range(99);
        if (pick < 12)
          load_curve(2'($urandom_range(NCH-1)), $urandom_range(99) < 85);
        else if (pick < 14)
          drain(1'b0);
        else if (pick < 38)
          issue(rand_item(plim_pkg::ACT_WRITE));
        else
          issue(rand_item(plim_pkg::ACT_MAP));
      end
    end
    drain(1'b1);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/plim_pkg.sv
sv/plim_point_mem.sv
sv/plim_divider.sv
sv/piecewise_linear_intensity_map_unit.sv
tb/sv/testbench.sv
